// ----- rtl/core/tmmc_pkg.sv -----
// shared types, constants and register codes for the tilt mouse motion conditioner
package tmmc_pkg;

	// sample and accumulator geometry
	localparam int SAMPLE_BITS = 10;
	// wide enough for the longest calibration run of full-scale samples
	localparam int SUM_W       = 22;
	localparam int MUL_W       = SUM_W + 2;
	localparam int PROD_W      = SUM_W + MUL_W;
	localparam int CLICK_SHIFT = 8;
	localparam int DELTA_LIMIT = 127;
	localparam int DELTA_W     = 8;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DEAD_ZONE      = 3'd0,
		CFG_MAX_CHANGE     = 3'd1,
		CFG_GAIN           = 3'd2,
		CFG_LEFT_THRESHOLD = 3'd3,
		CFG_RIGHT_LOW      = 3'd4,
		CFG_RIGHT_HIGH     = 3'd5
	} cfg_index_t;

	// register values after reset
	localparam logic [7:0] DEAD_ZONE_RST      = 8'd7;
	localparam logic [8:0] MAX_CHANGE_RST     = 9'd95;
	localparam logic [3:0] GAIN_RST           = 4'd2;
	localparam logic [9:0] LEFT_THRESHOLD_RST = 10'd90;
	localparam logic [9:0] RIGHT_LOW_RST      = 10'd60;
	localparam logic [9:0] RIGHT_HIGH_RST     = 10'd90;

	typedef struct packed {
		logic [7:0] dead_zone;
		logic [8:0] max_change;
		logic [3:0] gain;
		logic [9:0] left_threshold;
		logic [9:0] right_low;
		logic [9:0] right_high;
	} cfg_t;

	// what kind of run closed
	typedef enum logic {
		REC_CAL,
		REC_FRAME
	} rec_kind_t;

	// one closed run, handed from front to back
	typedef struct packed {
		rec_kind_t                kind;
		logic [SUM_W-1:0]         sum_x;
		logic [SUM_W-1:0]         sum_y;
		logic [SAMPLE_BITS-1:0]   left_level;
		logic [SAMPLE_BITS-1:0]   right_level;
	} frame_rec_t;

endpackage

// ----- rtl/core/tmmc_front.sv -----
// front end: takes sample beats, accumulates calibration runs and frames, emits run records
module tmmc_front #(
	parameter int CAL_SAMPLES   = 2048,
	parameter int AXIS_SAMPLES  = 64,
	parameter int FRAME_SAMPLES = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [9:0]             x_sample,
	input  logic [9:0]             y_sample,
	input  logic [9:0]             left_sample,
	input  logic [9:0]             right_sample,
	input  logic                   q_full,
	output logic                   q_push,
	output tmmc_pkg::frame_rec_t   q_rec,
	output logic                   calibrating
);

	localparam int SB      = tmmc_pkg::SAMPLE_BITS;
	localparam int SW      = tmmc_pkg::SUM_W;
	localparam int RUN_MAX = (CAL_SAMPLES > FRAME_SAMPLES) ? CAL_SAMPLES : FRAME_SAMPLES;
	localparam int CNT_W   = $clog2(RUN_MAX);
	localparam int CAL_W   = SB + $clog2(CAL_SAMPLES);
	localparam int AXIS_W  = SB + $clog2(AXIS_SAMPLES);
	localparam int XY_W    = (CAL_W > AXIS_W) ? CAL_W : AXIS_W;
	localparam int CLK_W   = SB + $clog2(FRAME_SAMPLES);

	logic              cal_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [XY_W-1:0]   sum_x_q, sum_y_q;
	logic [CLK_W-1:0]  sum_l_q, sum_r_q;

	logic              accept;
	logic              take_xy;
	logic              closing;
	logic [XY_W-1:0]   sum_x_nxt, sum_y_nxt;
	logic [CLK_W-1:0]  sum_l_nxt, sum_r_nxt;

	// classify the beat and form the running sums
	always_comb begin
		in_ready  = !q_full;
		accept    = in_valid && in_ready;
		take_xy   = cal_q || (int'(cnt_q) < AXIS_SAMPLES);
		closing   = cal_q ? (cnt_q == CNT_W'(CAL_SAMPLES - 1))
		                  : (cnt_q == CNT_W'(FRAME_SAMPLES - 1));
		sum_x_nxt = take_xy ? sum_x_q + XY_W'(x_sample[SB-1:0]) : sum_x_q;
		sum_y_nxt = take_xy ? sum_y_q + XY_W'(y_sample[SB-1:0]) : sum_y_q;
		sum_l_nxt = cal_q ? sum_l_q : sum_l_q + CLK_W'(left_sample[SB-1:0]);
		sum_r_nxt = cal_q ? sum_r_q : sum_r_q + CLK_W'(right_sample[SB-1:0]);

		q_push            = accept && closing;
		q_rec.kind        = cal_q ? tmmc_pkg::REC_CAL : tmmc_pkg::REC_FRAME;
		q_rec.sum_x       = SW'(sum_x_nxt);
		q_rec.sum_y       = SW'(sum_y_nxt);
		q_rec.left_level  = SB'(sum_l_nxt >> tmmc_pkg::CLICK_SHIFT);
		q_rec.right_level = SB'(sum_r_nxt >> tmmc_pkg::CLICK_SHIFT);
		calibrating       = cal_q;
	end

	// accumulators, sample counter and calibration flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q   <= 1'b1;
			cnt_q   <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_l_q <= '0;
			sum_r_q <= '0;
		end else if (accept) begin
			if (closing) begin
				cal_q   <= 1'b0;
				cnt_q   <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_l_q <= '0;
				sum_r_q <= '0;
			end else begin
				cnt_q   <= cnt_q + CNT_W'(1);
				sum_x_q <= sum_x_nxt;
				sum_y_q <= sum_y_nxt;
				sum_l_q <= sum_l_nxt;
				sum_r_q <= sum_r_nxt;
			end
		end
	end

endmodule

// ----- rtl/core/tmmc_queue.sv -----
// short queue of run records between front and back
module tmmc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tmmc_pkg::frame_rec_t  push_rec,
	output logic                  full,
	input  logic                  pop,
	output tmmc_pkg::frame_rec_t  pop_rec,
	output logic                  empty
);

	localparam int DEPTH = tmmc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tmmc_pkg::frame_rec_t entries_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push, do_pop;

	always_comb begin
		full    = (count_q == CNT_W'(DEPTH));
		empty   = (count_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		pop_rec = entries_q[rd_ptr_q];
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/tmmc_back.sv -----
// back end: averages, zero points, dead zone, clamp, gain and button logic
module tmmc_back #(
	parameter int CAL_SAMPLES  = 2048,
	parameter int AXIS_SAMPLES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmmc_pkg::cfg_t        cfg,
	input  logic                  q_empty,
	input  tmmc_pkg::frame_rec_t  q_rec,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [7:0]     delta_x,
	output logic signed [7:0]     delta_y,
	output logic                  left_button,
	output logic                  right_button
);

	localparam int SB     = tmmc_pkg::SAMPLE_BITS;
	localparam int SW     = tmmc_pkg::SUM_W;
	localparam int MW     = tmmc_pkg::MUL_W;
	localparam int PW     = tmmc_pkg::PROD_W;
	localparam int DW     = tmmc_pkg::DELTA_W;
	localparam int OFF_W  = SB + 1;
	localparam int SC_W   = OFF_W + 5;
	localparam int CAL_K  = SW + $clog2(CAL_SAMPLES);
	localparam int AXIS_K = SW + $clog2(AXIS_SAMPLES);
	// reciprocals, exact floor for every sum below 2**SUM_W
	localparam logic [MW-1:0] CAL_MUL =
		MW'(((64'd1 << CAL_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
	localparam logic [MW-1:0] AXIS_MUL =
		MW'(((64'd1 << AXIS_K) + 64'(AXIS_SAMPLES) - 64'd1) / 64'(AXIS_SAMPLES));
	localparam logic signed [SC_W-1:0] DLIM = SC_W'(tmmc_pkg::DELTA_LIMIT);

	// dead zone test and clamp of the offset from the zero point
	function automatic logic signed [OFF_W-1:0] clamp_offset(
		input logic [SB-1:0] avg,
		input logic [SB-1:0] zero,
		input logic [7:0]    dz,
		input logic [8:0]    mc
	);
		logic [OFF_W-1:0]        a, z;
		logic signed [OFF_W-1:0] off, lim, res;
		a   = {1'b0, avg};
		z   = {1'b0, zero};
		off = $signed(a) - $signed(z);
		lim = $signed(OFF_W'(mc));
		if ((a <= z + OFF_W'(dz)) && (a + OFF_W'(dz) >= z)) begin
			res = '0;
		end else if (off > lim) begin
			res = lim;
		end else if (off < -lim) begin
			res = -lim;
		end else begin
			res = off;
		end
		return res;
	endfunction

	// saturate a scaled offset to the delta range
	function automatic logic signed [DW-1:0] sat_delta(input logic signed [SC_W-1:0] v);
		logic signed [DW-1:0] res;
		if (v > DLIM) begin
			res = DW'(DLIM);
		end else if (v < -DLIM) begin
			res = DW'(-DLIM);
		end else begin
			res = DW'(v);
		end
		return res;
	endfunction

	logic                    adv;
	logic [MW-1:0]           mul_c;
	logic [PW-1:0]           prod_x, prod_y;

	logic                    valid_s1;
	tmmc_pkg::rec_kind_t     kind_s1;
	logic [PW-1:0]           prod_x_s1, prod_y_s1;
	logic [SB-1:0]           left_lvl_s1, right_lvl_s1;

	logic [SB-1:0]           avg_x, avg_y;
	logic                    cal_go, frame_go;
	logic signed [OFF_W-1:0] off_x, off_y;
	logic [SB-1:0]           peak_nxt;
	logic                    rising_nxt, held_nxt, right_nxt;

	logic [SB-1:0]           zero_x_q, zero_y_q, left_peak_q;
	logic                    peak_rising_q, left_held_q;

	logic                    valid_s2;
	logic signed [OFF_W-1:0] off_x_s2, off_y_s2;
	logic                    held_s2, right_s2;

	logic signed [SC_W-1:0]  scaled_x, scaled_y;

	logic                    valid_s3;
	logic signed [DW-1:0]    delta_x_s3, delta_y_s3;
	logic                    left_s3, right_s3;

	// pipeline moves when the output register is free or being taken
	always_comb begin
		adv   = !valid_s3 || out_ready;
		q_pop = adv && !q_empty;
		mul_c = (q_rec.kind == tmmc_pkg::REC_CAL) ? CAL_MUL : AXIS_MUL;
		prod_x = q_rec.sum_x * mul_c;
		prod_y = q_rec.sum_y * mul_c;
	end

	// stage two: averages, offsets and button state
	always_comb begin
		if (kind_s1 == tmmc_pkg::REC_CAL) begin
			avg_x = SB'(prod_x_s1 >> CAL_K);
			avg_y = SB'(prod_y_s1 >> CAL_K);
		end else begin
			avg_x = SB'(prod_x_s1 >> AXIS_K);
			avg_y = SB'(prod_y_s1 >> AXIS_K);
		end
		cal_go   = adv && valid_s1 && (kind_s1 == tmmc_pkg::REC_CAL);
		frame_go = adv && valid_s1 && (kind_s1 == tmmc_pkg::REC_FRAME);
		off_x    = clamp_offset(avg_x, zero_x_q, cfg.dead_zone, cfg.max_change);
		off_y    = clamp_offset(avg_y, zero_y_q, cfg.dead_zone, cfg.max_change);

		peak_nxt   = left_peak_q;
		rising_nxt = peak_rising_q;
		held_nxt   = left_held_q;
		if (left_lvl_s1 > left_peak_q) begin
			peak_nxt   = left_lvl_s1;
			rising_nxt = 1'b1;
		end else begin
			if ((left_peak_q >= cfg.left_threshold) && !left_held_q) begin
				held_nxt   = 1'b1;
				rising_nxt = 1'b0;
			end
			if ((left_peak_q > cfg.left_threshold) && held_nxt && rising_nxt) begin
				held_nxt = 1'b0;
			end
		end
		right_nxt = (right_lvl_s1 > cfg.right_low) && (right_lvl_s1 < cfg.right_high);
	end

	// stage three: gain and saturation
	always_comb begin
		scaled_x = off_x_s2 * $signed({1'b0, cfg.gain});
		scaled_y = off_y_s2 * $signed({1'b0, cfg.gain});
	end

	// control state: valid bits, zero points, left button tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			zero_x_q      <= '0;
			zero_y_q      <= '0;
			left_peak_q   <= '0;
			peak_rising_q <= 1'b0;
			left_held_q   <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= !q_empty;
				valid_s2 <= valid_s1 && (kind_s1 == tmmc_pkg::REC_FRAME);
				valid_s3 <= valid_s2;
			end
			if (cal_go) begin
				zero_x_q <= avg_x;
				zero_y_q <= avg_y;
			end
			if (frame_go) begin
				left_peak_q   <= peak_nxt;
				peak_rising_q <= rising_nxt;
				left_held_q   <= held_nxt;
			end
		end
	end

	// payload registers of the three stages
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1      <= q_rec.kind;
			prod_x_s1    <= prod_x;
			prod_y_s1    <= prod_y;
			left_lvl_s1  <= q_rec.left_level;
			right_lvl_s1 <= q_rec.right_level;
			off_x_s2     <= off_x;
			off_y_s2     <= off_y;
			held_s2      <= held_nxt;
			right_s2     <= right_nxt;
			delta_x_s3   <= sat_delta(scaled_x);
			delta_y_s3   <= sat_delta(scaled_y);
			left_s3      <= held_s2;
			right_s3     <= right_s2;
		end
	end

	assign out_valid    = valid_s3;
	assign delta_x      = delta_x_s3;
	assign delta_y      = delta_y_s3;
	assign left_button  = left_s3;
	assign right_button = right_s3;

endmodule

// ----- rtl/core/tilt_mouse_motion_conditioner_top.sv -----
// top level of the tilt mouse motion conditioner
// Input channel: one beat per four-channel ADC sample (x, y, left, right), valid/ready.
// Output channel: one beat per frame with delta_x, delta_y and both button states.
// Configuration: write-only port, cfg_we with cfg_index and cfg_data, taken at once;
// write only while no sample is in flight.
// After reset the first CAL_SAMPLES samples set the X and Y zero points and give no
// result; then every FRAME_SAMPLES samples give one result.
// Throughput: one sample per cycle while the queue has room, with no gaps at frame boundaries.
// The result of a frame passes from the beat that closes it through the queue, the
// multiply by the averaging reciprocal, the offset and button stage, and gain and
// saturation into the output register.
// Reset clears zero points, accumulators, button tracking and the registers to their
// defaults; the block then starts a new calibration run.
// When the receiver stalls, the result holds in the output register and the back
// pipeline freezes; two closed frames more fit in the queue, after which in_ready
// drops until the receiver takes a beat.
module tilt_mouse_motion_conditioner_top #(
	parameter int CAL_SAMPLES   = 2048,
	parameter int AXIS_SAMPLES  = 64,
	parameter int FRAME_SAMPLES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [9:0]         x_sample,
	input  logic [9:0]         y_sample,
	input  logic [9:0]         left_sample,
	input  logic [9:0]         right_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [7:0]  delta_x,
	output logic signed [7:0]  delta_y,
	output logic               left_button,
	output logic               right_button
);

	tmmc_pkg::cfg_t        cfg_q;
	tmmc_pkg::frame_rec_t  push_rec, pop_rec;
	logic                  q_push, q_full, q_pop, q_empty;
	logic                  calibrating;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone      <= tmmc_pkg::DEAD_ZONE_RST;
			cfg_q.max_change     <= tmmc_pkg::MAX_CHANGE_RST;
			cfg_q.gain           <= tmmc_pkg::GAIN_RST;
			cfg_q.left_threshold <= tmmc_pkg::LEFT_THRESHOLD_RST;
			cfg_q.right_low      <= tmmc_pkg::RIGHT_LOW_RST;
			cfg_q.right_high     <= tmmc_pkg::RIGHT_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tmmc_pkg::CFG_DEAD_ZONE:      cfg_q.dead_zone      <= cfg_data[7:0];
				tmmc_pkg::CFG_MAX_CHANGE:     cfg_q.max_change     <= cfg_data[8:0];
				tmmc_pkg::CFG_GAIN:           cfg_q.gain           <= cfg_data[3:0];
				tmmc_pkg::CFG_LEFT_THRESHOLD: cfg_q.left_threshold <= cfg_data;
				tmmc_pkg::CFG_RIGHT_LOW:      cfg_q.right_low      <= cfg_data;
				tmmc_pkg::CFG_RIGHT_HIGH:     cfg_q.right_high     <= cfg_data;
				default: ;
			endcase
		end
	end

	tmmc_front #(
		.CAL_SAMPLES   (CAL_SAMPLES),
		.AXIS_SAMPLES  (AXIS_SAMPLES),
		.FRAME_SAMPLES (FRAME_SAMPLES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_sample     (x_sample),
		.y_sample     (y_sample),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_rec        (push_rec),
		.calibrating  (calibrating)
	);

	tmmc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.pop_rec  (pop_rec),
		.empty    (q_empty)
	);

	tmmc_back #(
		.CAL_SAMPLES  (CAL_SAMPLES),
		.AXIS_SAMPLES (AXIS_SAMPLES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_rec        (pop_rec),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.left_button  (left_button),
		.right_button (right_button)
	);

	// a closed run never meets a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("run record pushed into a full queue");

	// no result before the zero points exist
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !calibrating)
		else $error("result beat during calibration");

	// calibration ends only by handing its run to the back end
	assert property (@(posedge clk) disable iff (!arst_n) $fell(calibrating) |-> $past(q_push))
		else $error("calibration ended without a run record");

endmodule

// ----- test/tb_tilt_mouse_motion_conditioner_top.sv -----
// self-checking testbench for the tilt mouse motion conditioner top level
`timescale 1ns / 1ps

module tb_tilt_mouse_motion_conditioner_top;

	localparam int CAL_LEN       = 2048;
	localparam int AXIS_LEN      = 64;
	localparam int FRAME_LEN     = 128;
	localparam int SETTLE_CYCLES = 8;
	localparam int RUN_LIMIT     = 300000;

	typedef struct packed {
		logic [9:0] x;
		logic [9:0] y;
		logic [9:0] l;
		logic [9:0] r;
	} adc_beat_t;

	typedef struct packed {
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic              lb;
		logic              rb;
	} motion_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [tmmc_pkg::CFG_INDEX_W-1:0] cfg_index = tmmc_pkg::CFG_DEAD_ZONE;
	logic [tmmc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [9:0]                       x_sample = '0;
	logic [9:0]                       y_sample = '0;
	logic [9:0]                       left_sample = '0;
	logic [9:0]                       right_sample = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic signed [7:0]                delta_x;
	logic signed [7:0]                delta_y;
	logic                             left_button;
	logic                             right_button;

	tilt_mouse_motion_conditioner_top #(
		.CAL_SAMPLES(CAL_LEN),
		.AXIS_SAMPLES(AXIS_LEN),
		.FRAME_SAMPLES(FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_sample(x_sample),
		.y_sample(y_sample),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.delta_x(delta_x),
		.delta_y(delta_y),
		.left_button(left_button),
		.right_button(right_button)
	);

	// register copies, reset values
	logic [7:0] cfg_dead_zone      = tmmc_pkg::DEAD_ZONE_RST;
	logic [8:0] cfg_max_change     = tmmc_pkg::MAX_CHANGE_RST;
	logic [3:0] cfg_gain           = tmmc_pkg::GAIN_RST;
	logic [9:0] cfg_left_threshold = tmmc_pkg::LEFT_THRESHOLD_RST;
	logic [9:0] cfg_right_low      = tmmc_pkg::RIGHT_LOW_RST;
	logic [9:0] cfg_right_high     = tmmc_pkg::RIGHT_HIGH_RST;

	// conditioner state as predicted
	bit          cal_run = 1'b1;
	logic [11:0] beat_count = '0;
	logic [20:0] acc_x = '0;
	logic [20:0] acc_y = '0;
	logic [16:0] acc_l = '0;
	logic [16:0] acc_r = '0;
	logic [9:0]  zero_x = '0;
	logic [9:0]  zero_y = '0;
	logic [9:0]  peak_level = '0;
	bit          peak_rising = 1'b0;
	bit          left_held = 1'b0;

	adc_beat_t sample_q[$];
	motion_t   expected_motion_q[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        sender_idle_pct = 0;
	int        receiver_idle_pct = 0;

	// stimulus side view of where the zero points and the left peak sit
	int gen_zero_x = 512;
	int gen_zero_y = 512;
	int gen_peak = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// dead zone, clamp, gain and saturation for one axis
	function automatic logic signed [7:0] axis_motion(input int avg, input int zero);
		int dz;
		int mc;
		int off;
		int d;
		dz = cfg_dead_zone;
		mc = cfg_max_change;
		if (avg <= zero + dz && avg >= zero - dz)
			return '0;
		off = avg - zero;
		if (off > mc)
			off = mc;
		else if (off < -mc)
			off = -mc;
		d = off * int'(cfg_gain);
		if (d > tmmc_pkg::DELTA_LIMIT)
			d = tmmc_pkg::DELTA_LIMIT;
		if (d < -tmmc_pkg::DELTA_LIMIT)
			d = -tmmc_pkg::DELTA_LIMIT;
		return 8'(d);
	endfunction

	// advance the predicted state by one sample beat; 1 when a frame closes
	function automatic bit predict_motion(input adc_beat_t b, output motion_t m);
		logic [9:0] lvl_l;
		logic [9:0] lvl_r;
		m = '0;
		if (cal_run) begin
			acc_x += 21'(b.x);
			acc_y += 21'(b.y);
			beat_count++;
			if (beat_count >= CAL_LEN) begin
				zero_x = 10'(acc_x / CAL_LEN);
				zero_y = 10'(acc_y / CAL_LEN);
				acc_x = '0;
				acc_y = '0;
				beat_count = '0;
				cal_run = 1'b0;
			end
			return 1'b0;
		end
		if (beat_count < AXIS_LEN) begin
			acc_x += 21'(b.x);
			acc_y += 21'(b.y);
		end
		acc_l += 17'(b.l);
		acc_r += 17'(b.r);
		beat_count++;
		if (beat_count < FRAME_LEN)
			return 1'b0;

		m.dx = axis_motion(int'(acc_x) / AXIS_LEN, int'(zero_x));
		m.dy = axis_motion(int'(acc_y) / AXIS_LEN, int'(zero_y));
		lvl_l = 10'(acc_l >> tmmc_pkg::CLICK_SHIFT);
		lvl_r = 10'(acc_r >> tmmc_pkg::CLICK_SHIFT);

		// left: peak then fall toggles the button, the peak never decays
		if (lvl_l > peak_level) begin
			peak_level = lvl_l;
			peak_rising = 1'b1;
		end else begin
			if (peak_level >= cfg_left_threshold && !left_held) begin
				left_held = 1'b1;
				peak_rising = 1'b0;
			end
			if (peak_level > cfg_left_threshold && left_held && peak_rising)
				left_held = 1'b0;
		end
		m.lb = left_held;
		m.rb = (lvl_r > cfg_right_low) && (lvl_r < cfg_right_high);

		acc_x = '0;
		acc_y = '0;
		acc_l = '0;
		acc_r = '0;
		beat_count = '0;
		return 1'b1;
	endfunction

	// sample driver, fed from the pending queue
	always @(posedge clk or negedge arst_n) begin
		adc_beat_t beat;
		motion_t   res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				beat = '{x: x_sample, y: y_sample, l: left_sample, r: right_sample};
				if (predict_motion(beat, res))
					expected_motion_q.push_back(res);
			end
			if (!in_valid || in_ready) begin
				if (sample_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
					beat = sample_q.pop_front();
					in_valid <= 1'b1;
					x_sample <= beat.x;
					y_sample <= beat.y;
					left_sample <= beat.l;
					right_sample <= beat.r;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		motion_t got;
		motion_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{dx: delta_x, dy: delta_y, lb: left_button, rb: right_button};
				if (expected_motion_q.size() == 0) begin
					report_mismatch("result beat with none expected");
				end else begin
					want = expected_motion_q.pop_front();
					if (got.dx !== want.dx)
						report_mismatch($sformatf("delta_x %0d, expected %0d", got.dx, want.dx));
					if (got.dy !== want.dy)
						report_mismatch($sformatf("delta_y %0d, expected %0d", got.dy, want.dy));
					if (got.lb !== want.lb)
						report_mismatch($sformatf("left_button %b, expected %b", got.lb, want.lb));
					if (got.rb !== want.rb)
						report_mismatch($sformatf("right_button %b, expected %b", got.rb, want.rb));
				end
			end
			out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
		end
	end

	function automatic int clip(input int v, input int hi);
		return (v < 0) ? 0 : (v > hi) ? hi : v;
	endfunction

	// axis sample: first window averages exactly to the target, negative target is noise
	function automatic logic [9:0] axis_sample(input int target, input int i);
		if (target < 0 || i >= AXIS_LEN)
			return 10'($urandom_range(1023, 0));
		if (i == 0 || target == 1023)
			return 10'(target);
		return 10'(target + int'($urandom_range(1, 0)));
	endfunction

	// click sample: frame sum shifted down gives the target, with the odd spike
	function automatic logic [9:0] click_sample(input int target);
		if (target < 0 || $urandom_range(99, 0) == 0)
			return 10'($urandom_range(1023, 0));
		return 10'(2 * target + int'($urandom_range(1, 0)));
	endfunction

	task automatic push_frame(input int xt, input int yt, input int lt, input int rt);
		adc_beat_t b;
		for (int i = 0; i < FRAME_LEN; i++) begin
			b.x = axis_sample(xt, i);
			b.y = axis_sample(yt, i);
			b.l = click_sample(lt);
			b.r = click_sample(rt);
			sample_q.push_back(b);
		end
		if (lt > gen_peak)
			gen_peak = lt;
	endtask

	function automatic int axis_target(input int zero);
		int span;
		span = cfg_max_change + cfg_dead_zone + 10;
		case ($urandom_range(3, 0))
			0: return -1;
			1: return clip(zero + ($urandom_range(1, 0) ? 1 : -1) *
				(int'(cfg_dead_zone) + int'($urandom_range(2, 0)) - 1), 1023);
			2: return $urandom_range(1023, 0);
			default: return clip(zero + int'($urandom_range(2 * span, 0)) - span, 1023);
		endcase
	endfunction

	task automatic push_random_frame();
		int lt;
		int rt;
		if ($urandom_range(1, 0))
			lt = clip(gen_peak + int'($urandom_range(6, 1)), 511);
		else
			lt = $urandom_range(gen_peak, 0);
		case ($urandom_range(3, 0))
			0: rt = clip(int'(cfg_right_low) + int'($urandom_range(2, 0)) - 1, 511);
			1: rt = clip(int'(cfg_right_high) + int'($urandom_range(2, 0)) - 1, 511);
			2: rt = $urandom_range(511, 0);
			default: rt = $urandom_range(127, 0);
		endcase
		push_frame(axis_target(gen_zero_x), axis_target(gen_zero_y), lt, rt);
	endtask

	task automatic write_reg(input tmmc_pkg::cfg_index_t idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[9:0];
		case (idx)
			tmmc_pkg::CFG_DEAD_ZONE:      cfg_dead_zone = val[7:0];
			tmmc_pkg::CFG_MAX_CHANGE:     cfg_max_change = val[8:0];
			tmmc_pkg::CFG_GAIN:           cfg_gain = val[3:0];
			tmmc_pkg::CFG_LEFT_THRESHOLD: cfg_left_threshold = val[9:0];
			tmmc_pkg::CFG_RIGHT_LOW:      cfg_right_low = val[9:0];
			tmmc_pkg::CFG_RIGHT_HIGH:     cfg_right_high = val[9:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int dz, input int mc, input int g, input int lt,
			input int rl, input int rh);
		write_reg(tmmc_pkg::CFG_DEAD_ZONE, dz);
		write_reg(tmmc_pkg::CFG_MAX_CHANGE, mc);
		write_reg(tmmc_pkg::CFG_GAIN, g);
		write_reg(tmmc_pkg::CFG_LEFT_THRESHOLD, lt);
		write_reg(tmmc_pkg::CFG_RIGHT_LOW, rl);
		write_reg(tmmc_pkg::CFG_RIGHT_HIGH, rh);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		int rl;
		rl = $urandom_range(300, 0);
		set_config($urandom_range(40, 0), $urandom_range(160, 0), $urandom_range(15, 0),
			clip(gen_peak - 5 + int'($urandom_range(25, 0)), 1023),
			rl, rl + int'($urandom_range(120, 0)));
	endtask

	// hold off the sender until every result is in and the pipeline has drained
	task automatic wait_idle();
		while (sample_q.size() != 0 || in_valid || expected_motion_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random_phase(input int frames);
		for (int f = 0; f < frames; f++)
			push_random_frame();
		wait_idle();
	endtask

	initial begin
		adc_beat_t b;
		int sum_x;
		int sum_y;
		int dz;

		sender_idle_pct = 12;
		receiver_idle_pct = 54;

		// calibration run around mid scale
		sum_x = 0;
		sum_y = 0;
		for (int i = 0; i < CAL_LEN; i++) begin
			b.x = 10'($urandom_range(640, 384));
			b.y = 10'($urandom_range(640, 384));
			b.l = 10'($urandom_range(1023, 0));
			b.r = 10'($urandom_range(1023, 0));
			sum_x += int'(b.x);
			sum_y += int'(b.y);
			sample_q.push_back(b);
		end
		gen_zero_x = sum_x / CAL_LEN;
		gen_zero_y = sum_y / CAL_LEN;
		dz = int'(tmmc_pkg::DEAD_ZONE_RST);

		// directed frames at reset settings
		push_frame(gen_zero_x, gen_zero_y, 0, 0);
		push_frame(gen_zero_x + dz, gen_zero_y - dz, 61, 61);
		push_frame(gen_zero_x + dz + 1, gen_zero_y - dz - 1, 60, 60);
		push_frame(1023, 0, 89, 89);
		push_frame(0, 1023, 90, 90);
		// fall after peak at threshold presses left
		push_frame(gen_zero_x + 50, gen_zero_y - 50, 50, 75);
		push_frame(gen_zero_x, gen_zero_y, 120, 0);
		// new peak then fall releases
		push_frame(gen_zero_x, gen_zero_y, 100, 0);
		push_frame(gen_zero_x, gen_zero_y, 50, 0);
		push_frame(-1, -1, 40, -1);
		push_frame(1023, 1023, 130, 300);
		push_frame(0, 0, 10, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// all registers at their lowest
		set_config(0, 0, 0, 0, 0, 0);
		run_random_phase(2);

		// all registers at their highest, limits crossed
		set_config(255, 511, 15, 1023, 1023, 1023);
		run_random_phase(2);

		sender_idle_pct = 54;
		receiver_idle_pct = 12;
		// clamp tighter than the dead zone, one-wide right window
		set_config(30, 10, 15, clip(gen_peak + 3, 1023), 100, 102);
		run_random_phase(2);
		random_config();
		run_random_phase(2);

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		random_config();
		run_random_phase(2);
		random_config();
		run_random_phase(2);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/tmmc_pkg.sv
rtl/core/tmmc_front.sv
rtl/core/tmmc_queue.sv
rtl/core/tmmc_back.sv
rtl/core/tilt_mouse_motion_conditioner_top.sv
test/tb_tilt_mouse_motion_conditioner_top.sv
